>>> rtl/job_queue_affinity_delay_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the job dispatcher.
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOB_QUEUE_AFFINITY_DELAY_TOP_ASSERT_SVH
`define JOB_QUEUE_AFFINITY_DELAY_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define JQAD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define JQAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jqad_pkg.sv
// ----------------------------------------------------------------------------
// jqad_pkg
// Types, sizes and codes shared by the job dispatcher modules.
// ----------------------------------------------------------------------------
package jqad_pkg;

	localparam int RD_DEPTH = 16;
	localparam int DL_DEPTH = 16;
	localparam int RD_IW = $clog2(RD_DEPTH);
	localparam int DL_IW = $clog2(DL_DEPTH);
	localparam int RD_FW = $clog2(RD_DEPTH + 1);
	localparam int DL_FW = $clog2(DL_DEPTH + 1);
	localparam int SCAN_W = (RD_FW > DL_FW) ? RD_FW : DL_FW;

	localparam int OWN_W = 9;
	localparam logic [OWN_W-1:0] OWNER_LIMIT = 9'd256;

	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_DLY = 2'd1;
	localparam logic [1:0] KIND_DEQ = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	localparam logic [4:0] MOVED_MAX = 5'd31;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       job_tag;
		logic [OWN_W-1:0] worker_id;
		logic [15:0]      delay_ms;
		logic [15:0]      elapsed;
	} jqad_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] found_tag;
		logic [4:0] moved_count;
	} jqad_rsp_t;

	typedef struct packed {
		logic load;
		logic step;
	} jqad_cmd_t;

	typedef struct packed {
		logic done;
	} jqad_sts_t;

endpackage

>>> rtl/jqad_datapath.sv
// ----------------------------------------------------------------------------
// jqad_datapath
// Ready queue, delay list, scan index and result registers.
// ----------------------------------------------------------------------------
module jqad_datapath import jqad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  jqad_cmd_t cmd,
	input  jqad_req_t req,
	output jqad_sts_t sts,
	output jqad_rsp_t rsp
);

	logic [7:0]       rtag_q [RD_DEPTH];
	logic [OWN_W-1:0] rown_q [RD_DEPTH];
	logic [RD_FW-1:0] rfill_q;
	logic [7:0]       dtag_q [DL_DEPTH];
	logic [15:0]      drem_q [DL_DEPTH];
	logic [DL_FW-1:0] dfill_q;

	logic [1:0]        kind_q;
	logic [7:0]        tag_q;
	logic [OWN_W-1:0]  own_q;
	logic [15:0]       dly_q;
	logic [15:0]       ela_q;
	logic [SCAN_W-1:0] idx_q;
	jqad_rsp_t         res_q;

	logic [RD_IW-1:0]  ri;
	logic [SCAN_W-1:0] jm1;
	logic [DL_IW-1:0]  dj;
	logic rfull, dfull, rd_end, rd_hit, tk_end, tk_exp, tk_push;
	logic r_wr, r_del, d_wr, d_del, d_upd;
	logic [7:0]       r_wtag;
	logic [OWN_W-1:0] r_wown;
	logic [OWN_W-1:0] own_in;

	assign own_in = (req.worker_id > OWNER_LIMIT) ? OWNER_LIMIT : req.worker_id;

	always_comb begin
		ri = idx_q[RD_IW-1:0];
		jm1 = idx_q - SCAN_W'(1);
		dj = jm1[DL_IW-1:0];
		rfull = (rfill_q == RD_FW'(RD_DEPTH));
		dfull = (dfill_q == DL_FW'(DL_DEPTH));
		rd_end = (idx_q >= SCAN_W'(rfill_q));
		rd_hit = !rd_end && (rown_q[ri] == own_q);
		tk_end = (idx_q == '0);
		tk_exp = (drem_q[dj] <= ela_q);
		tk_push = tk_exp && !rfull;
		r_wr = cmd.step && (((kind_q == KIND_ENQ) && !rfull) ||
			((kind_q == KIND_TICK) && !tk_end && tk_push));
		r_del = cmd.step && (kind_q == KIND_DEQ) && rd_hit;
		d_wr = cmd.step && (kind_q == KIND_DLY) && !dfull;
		d_del = cmd.step && (kind_q == KIND_TICK) && !tk_end && tk_push;
		d_upd = cmd.step && (kind_q == KIND_TICK) && !tk_end;
		r_wtag = (kind_q == KIND_TICK) ? dtag_q[dj] : tag_q;
		r_wown = (kind_q == KIND_TICK) ? '0 : own_q;
		sts.done = cmd.step && ((kind_q == KIND_ENQ) || (kind_q == KIND_DLY) ||
			((kind_q == KIND_DEQ) && (rd_end || rd_hit)) ||
			((kind_q == KIND_TICK) && tk_end));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rfill_q <= '0;
			dfill_q <= '0;
			idx_q <= '0;
			kind_q <= KIND_ENQ;
		end else begin
			if (cmd.load) begin
				kind_q <= req.kind;
				idx_q <= (req.kind == KIND_TICK) ? SCAN_W'(dfill_q) : '0;
			end else if (cmd.step && !sts.done) begin
				if (kind_q == KIND_DEQ) begin
					idx_q <= idx_q + SCAN_W'(1);
				end else begin
					idx_q <= jm1;
				end
			end
			if (r_wr) begin
				rfill_q <= rfill_q + RD_FW'(1);
			end else if (r_del) begin
				rfill_q <= rfill_q - RD_FW'(1);
			end
			if (d_wr) begin
				dfill_q <= dfill_q + DL_FW'(1);
			end else if (d_del) begin
				dfill_q <= dfill_q - DL_FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q <= req.job_tag;
			own_q <= own_in;
			dly_q <= req.delay_ms;
			ela_q <= req.elapsed;
			res_q.status <= (req.kind == KIND_DEQ) ? ST_NONE : ST_OK;
			res_q.found_tag <= '0;
			res_q.moved_count <= '0;
		end
		if (cmd.step && (((kind_q == KIND_ENQ) && rfull) || ((kind_q == KIND_DLY) && dfull) ||
			((kind_q == KIND_TICK) && !tk_end && tk_exp && rfull))) begin
			res_q.status <= ST_FULL;
		end
		if (r_del) begin
			res_q.status <= ST_OK;
			res_q.found_tag <= rtag_q[ri];
		end
		if (d_del && (res_q.moved_count != MOVED_MAX)) begin
			res_q.moved_count <= res_q.moved_count + 5'd1;
		end
		for (int k = 0; k < RD_DEPTH; k++) begin
			if (r_del && (SCAN_W'(k) >= idx_q) && (k < RD_DEPTH - 1)) begin
				rtag_q[k] <= rtag_q[k+1];
				rown_q[k] <= rown_q[k+1];
			end else if (r_wr && (RD_FW'(k) == rfill_q)) begin
				rtag_q[k] <= r_wtag;
				rown_q[k] <= r_wown;
			end
		end
		for (int k = 0; k < DL_DEPTH; k++) begin
			if (d_del && (DL_IW'(k) >= dj) && (k < DL_DEPTH - 1)) begin
				dtag_q[k] <= dtag_q[k+1];
				drem_q[k] <= drem_q[k+1];
			end else if (d_upd && (DL_IW'(k) == dj)) begin
				drem_q[k] <= tk_exp ? 16'd0 : (drem_q[k] - ela_q);
			end else if (d_wr && (DL_FW'(k) == dfill_q)) begin
				dtag_q[k] <= tag_q;
				drem_q[k] <= dly_q;
			end
		end
	end

	assign rsp = res_q;

endmodule

>>> rtl/jqad_ctrl.sv
// ----------------------------------------------------------------------------
// jqad_ctrl
// Sequencer: takes an item, steps the datapath, then offers the result.
// ----------------------------------------------------------------------------
`include "job_queue_affinity_delay_top_assert.svh"

module jqad_ctrl import jqad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  jqad_sts_t sts,
	output jqad_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_BUSY = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0] state_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_HOLD);
	assign cmd.load = (state_q == S_IDLE) && req_valid;
	assign cmd.step = (state_q == S_BUSY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_BUSY;
				end
				S_BUSY: begin
					if (sts.done) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (!rsp_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`JQAD_ASSERT_NOW(a_done_busy, sts.done, state_q == S_BUSY, "done outside busy")
	`JQAD_ASSERT_NEXT(a_load_busy, cmd.load, state_q == S_BUSY, "load did not start work")
	`JQAD_ASSERT_NEXT(a_deliver_idle, rsp_valid && !rsp_stall, state_q == S_IDLE,
		"result not retired")

endmodule

>>> rtl/job_queue_affinity_delay_top.sv
// ----------------------------------------------------------------------------
// job_queue_affinity_delay_top
// Job dispatcher with worker affinity and a delay list. Each item is one of
// enqueue, delayed enqueue, dequeue for a worker, or time tick, and it gives
// exactly one result item. Items are handled one at a time: an item is loaded,
// then an enqueue of either kind is stored, a dequeue compares one queue entry
// per cycle until it finds one for the worker or passes the ready fill, and a
// tick ages one delay entry per cycle, from the last entry down to the first;
// the result is then held until it is taken. Owner ids above 256 are treated
// as 256. The stores need no clearing after reset, so the block takes items
// right away.
// ----------------------------------------------------------------------------
module job_queue_affinity_delay_top import jqad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  jqad_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output jqad_rsp_t rsp
);

	// Command and status between the sequencer and the datapath.
	jqad_cmd_t cmd;
	jqad_sts_t sts;

	// The sequencer owns the handshakes and steps the datapath until it is done.
	jqad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds both stores and the result register.
	jqad_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
